@@ hdl/cartesian_polar_converter_assert.svh @@
// assertion macros shared by the checking code of the converter
`ifndef CARTESIAN_POLAR_CONVERTER_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_ASSERT_SVH

// same-cycle implication
`define CPC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("converter check failed");

// next-cycle implication
`define CPC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("converter check failed");

`endif

@@ hdl/cpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared constants, opcodes and the arctangent table of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpc_pkg;

	localparam int DEF_ITERATIONS = 16;
	localparam int DEF_DATA_WIDTH = 16;
	localparam int GUARD_BITS     = 3;
	localparam int TABLE_LEN      = 24;
	localparam int QUEUE_DEPTH    = 4;

	localparam logic OP_RECT_TO_POLAR = 1'b0;
	localparam logic OP_POLAR_TO_RECT = 1'b1;

	localparam logic [29:0] INVK      = 30'd652032874;
	localparam logic [31:0] QUARTER   = 32'h4000_0000;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] ANG_RND   = 32'h0000_8000;

	localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
		32'd536870912, 32'd316933405, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// op, zero flag, x, y and the 32-bit angle
	function automatic int item_bits(input int dw);
		return 2 * (dw + GUARD_BITS) + 34;
	endfunction

endpackage

@@ hdl/cpc_front.sv @@
// ----------------------------------------------------------------------------
// cpc_front
// Accepts transactions, scales operands and sets up the first CORDIC vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpc_front import cpc_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  opcode,
	input  logic signed [15:0]                    first_in,
	input  logic signed [15:0]                    second_in,
	input  logic                                  q_full,
	output logic                                  q_wr,
	output logic [item_bits(DATA_WIDTH)-1:0]      q_wdata
);

	localparam int W  = DATA_WIDTH + GUARD_BITS;
	localparam int F  = DATA_WIDTH - 2;
	localparam int UP = (F >= 14) ? F - 14 : 0;
	localparam int DN = (F < 14) ? 14 - F : 0;

	typedef struct packed {
		logic                op;
		logic                zero;
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic [31:0]         z;
	} cordic_t;

	function automatic logic signed [W-1:0] to_internal(input logic signed [15:0] q);
		logic signed [W-1:0] e;
		e = W'(q);
		return (e <<< UP) >>> DN;
	endfunction

	cordic_t             item;
	logic signed [W-1:0] a;
	logic signed [W-1:0] b;
	logic [31:0]         zr;

	always_comb begin
		a  = to_internal(first_in);
		b  = to_internal(second_in);
		zr = {second_in, 16'h0000};
		item      = '0;
		item.op   = opcode;
		if (opcode == OP_RECT_TO_POLAR) begin
			item.zero = (a == '0) && (b == '0);
			item.x    = a;
			item.y    = b;
			item.z    = '0;
			if (a[W-1]) begin
				if (!b[W-1]) begin
					item.x = b;
					item.y = -a;
					item.z = QUARTER;
				end else begin
					item.x = -b;
					item.y = a;
					item.z = 32'(0) - QUARTER;
				end
			end
		end else begin
			item.zero = 1'b0;
			item.x    = a;
			item.y    = '0;
			item.z    = zr;
			if (((zr + QUARTER) & HALF_TURN) != '0) begin
				item.x = -a;
				item.z = zr + HALF_TURN;
			end
		end
	end

	assign full    = q_full;
	assign q_wr    = push && !q_full;
	assign q_wdata = item;

endmodule

@@ hdl/cpc_queue.sv @@
// ----------------------------------------------------------------------------
// cpc_queue
// Short shifting queue between the front and the CORDIC back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpc_queue import cpc_pkg::*; #(
	parameter int WIDTH = item_bits(DEF_DATA_WIDTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] head,
	output logic             full,
	output logic             empty
);

	localparam int D  = QUEUE_DEPTH;
	localparam int AW = (D > 1) ? $clog2(D) : 1;
	localparam int CW = $clog2(D + 1);

	logic [WIDTH-1:0] ent_q [D];
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    wr_pos;
	logic [AW-1:0]    wr_idx;

	assign full   = (count_q == CW'(D));
	assign empty  = (count_q == '0);
	assign head   = ent_q[0];
	assign wr_pos = rd ? count_q - CW'(1) : count_q;
	assign wr_idx = wr_pos[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + CW'(wr) - CW'(rd);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < D - 1; i++) begin
			if (wr && (wr_idx == AW'(i))) begin
				ent_q[i] <= wdata;
			end else if (rd) begin
				ent_q[i] <= ent_q[i + 1];
			end
		end
		if (wr && (wr_idx == AW'(D - 1))) begin
			ent_q[D - 1] <= wdata;
		end
	end

endmodule

@@ hdl/cpc_back.sv @@
// ----------------------------------------------------------------------------
// cpc_back
// Pipelined CORDIC micro-rotations, gain compensation and output rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpc_back import cpc_pkg::*; #(
	parameter int ITERATIONS = DEF_ITERATIONS,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_empty,
	input  logic [item_bits(DATA_WIDTH)-1:0] q_head,
	output logic                             q_pop,
	output logic                             empty,
	input  logic                             pop,
	output logic signed [16:0]               first_out,
	output logic signed [15:0]               second_out
);

	localparam int W   = DATA_WIDTH + GUARD_BITS;
	localparam int F   = DATA_WIDTH - 2;
	localparam int S   = F + 16;
	localparam int LO  = (W + 1) / 2;
	localparam int HI  = W - LO;
	localparam int HPW = HI + 30;
	localparam int LPW = LO + 30;
	localparam int PW  = W + 31;
	localparam int RW  = PW - S + 1;

	localparam logic [PW-1:0]        RND  = PW'(1) << (S - 1);
	localparam logic signed [RW-1:0] MAX1 = RW'(65535);
	localparam logic signed [RW-1:0] MIN1 = RW'(-65536);
	localparam logic signed [RW-1:0] MAX2 = RW'(32767);
	localparam logic signed [RW-1:0] MIN2 = RW'(-32768);

	typedef struct packed {
		logic                op;
		logic                zero;
		logic signed [W-1:0] x;
		logic signed [W-1:0] y;
		logic [31:0]         z;
	} cordic_t;

	typedef struct packed {
		logic           op;
		logic           zero;
		logic           xn;
		logic           yn;
		logic [HPW-1:0] xh;
		logic [LPW-1:0] xl;
		logic [HPW-1:0] yh;
		logic [LPW-1:0] yl;
		logic [15:0]    ang;
	} prod_t;

	logic                en;
	logic [ITERATIONS:0] iter_vld_s;
	cordic_t             iter_s  [ITERATIONS+1];
	cordic_t             iter_nx [ITERATIONS];
	logic                prod_vld_s1;
	prod_t               prod_s1;
	prod_t               prod_d;
	logic                res_vld_s2;
	logic signed [16:0]  first_s2;
	logic signed [15:0]  second_s2;
	logic signed [16:0]  first_d;
	logic signed [15:0]  second_d;

	assign en         = !res_vld_s2 || pop;
	assign q_pop      = en && !q_empty;
	assign empty      = !res_vld_s2;
	assign first_out  = first_s2;
	assign second_out = second_s2;

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
		cordic_t             cur;
		cordic_t             nxt;
		logic signed [W-1:0] dx;
		logic signed [W-1:0] dy;
		logic                sel;

		always_comb begin
			cur = iter_s[k];
			dx  = cur.y >>> k;
			dy  = cur.x >>> k;
			sel = (cur.op == OP_POLAR_TO_RECT) ? cur.z[31] : !cur.y[W-1];
			nxt = cur;
			if (sel) begin
				nxt.x = cur.x + dx;
				nxt.y = cur.y - dy;
				nxt.z = cur.z + ATAN_TABLE[k];
			end else begin
				nxt.x = cur.x - dx;
				nxt.y = cur.y + dy;
				nxt.z = cur.z - ATAN_TABLE[k];
			end
		end

		assign iter_nx[k] = nxt;
	end

	// magnitude split into two partial products per coordinate
	always_comb begin
		cordic_t      t;
		logic [W-1:0] mx;
		logic [W-1:0] my;
		logic [31:0]  za;
		t  = iter_s[ITERATIONS];
		mx = t.x[W-1] ? W'(-t.x) : W'(t.x);
		my = t.y[W-1] ? W'(-t.y) : W'(t.y);
		za = t.z + ANG_RND;
		prod_d.op   = t.op;
		prod_d.zero = t.zero;
		prod_d.xn   = t.x[W-1];
		prod_d.yn   = t.y[W-1];
		prod_d.xh   = HPW'(mx[W-1:LO]) * HPW'(INVK);
		prod_d.xl   = LPW'(mx[LO-1:0]) * LPW'(INVK);
		prod_d.yh   = HPW'(my[W-1:LO]) * HPW'(INVK);
		prod_d.yl   = LPW'(my[LO-1:0]) * LPW'(INVK);
		prod_d.ang  = za[31:16];
	end

	always_comb begin
		logic [PW-1:0]        sx;
		logic [PW-1:0]        sy;
		logic signed [RW-1:0] rx;
		logic signed [RW-1:0] ry;
		logic signed [RW-1:0] cx;
		logic signed [RW-1:0] cy;
		sx = (PW'(prod_s1.xh) << LO) + PW'(prod_s1.xl) + RND;
		sy = (PW'(prod_s1.yh) << LO) + PW'(prod_s1.yl) + RND;
		rx = $signed({1'b0, sx[PW-1:S]});
		ry = $signed({1'b0, sy[PW-1:S]});
		if (prod_s1.xn) begin
			rx = -rx;
		end
		if (prod_s1.yn) begin
			ry = -ry;
		end
		cx = (rx > MAX1) ? MAX1 : ((rx < MIN1) ? MIN1 : rx);
		cy = (ry > MAX2) ? MAX2 : ((ry < MIN2) ? MIN2 : ry);
		first_d = cx[16:0];
		if (prod_s1.op == OP_POLAR_TO_RECT) begin
			second_d = cy[15:0];
		end else begin
			second_d = prod_s1.ang;
		end
		if (prod_s1.zero) begin
			first_d  = '0;
			second_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_vld_s  <= '0;
			prod_vld_s1 <= 1'b0;
			res_vld_s2  <= 1'b0;
		end else if (en) begin
			iter_vld_s  <= {iter_vld_s[ITERATIONS-1:0], !q_empty};
			prod_vld_s1 <= iter_vld_s[ITERATIONS];
			res_vld_s2  <= prod_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iter_s[0] <= q_head;
			for (int k = 0; k < ITERATIONS; k++) begin
				iter_s[k + 1] <= iter_nx[k];
			end
			prod_s1   <= prod_d;
			first_s2  <= first_d;
			second_s2 <= second_d;
		end
	end

endmodule

@@ hdl/cartesian_polar_converter.sv @@
// ----------------------------------------------------------------------------
// cartesian_polar_converter: CORDIC rectangular/polar conversion
// throughput: one transaction per cycle while the output is not held back by pop,
// set by the one-stage-per-rotation pipeline
// reset: asynchronous, clears queue fill and pipeline valid bits only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cartesian_polar_converter_assert.svh"

module cartesian_polar_converter import cpc_pkg::*; #(
	parameter int ITERATIONS = DEF_ITERATIONS,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               opcode,
	input  logic signed [15:0] first_in,
	input  logic signed [15:0] second_in,
	output logic               empty,
	input  logic               pop,
	output logic signed [16:0] first_out,
	output logic signed [15:0] second_out
);

	localparam int IW = item_bits(DATA_WIDTH);

	logic          q_full;
	logic          q_empty;
	logic          q_wr;
	logic          q_pop;
	logic [IW-1:0] q_wdata;
	logic [IW-1:0] q_head;

	cpc_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.push      (push),
		.full      (full),
		.opcode    (opcode),
		.first_in  (first_in),
		.second_in (second_in),
		.q_full    (q_full),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata)
	);

	cpc_queue #(
		.WIDTH(IW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_wr),
		.wdata (q_wdata),
		.rd    (q_pop),
		.head  (q_head),
		.full  (q_full),
		.empty (q_empty)
	);

	cpc_back #(
		.ITERATIONS(ITERATIONS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.first_out (first_out),
		.second_out(second_out)
	);

	`CPC_ASSERT_NXT(a_push_lands, push && !full && q_empty, !q_empty)
	`CPC_ASSERT_NXT(a_stall_keeps_queue, !empty && !pop && !q_empty, !q_empty)
	`CPC_ASSERT_IMP(a_full_not_empty, full, !q_empty)

endmodule

@@ test/tb_cartesian_polar_converter.sv @@
// ----------------------------------------------------------------------------
// tb_cartesian_polar_converter
// Drives rectangular-to-polar and polar-to-rectangular transactions with
// random idling on both sides and a long result hold-off that fills the
// block. Every result is checked field by field against a bit-exact CORDIC
// prediction computed when its transaction is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cartesian_polar_converter;
	import cpc_pkg::*;

	localparam int ITERS       = DEF_ITERATIONS;
	localparam int DW          = DEF_DATA_WIDTH;
	localparam int FRAC        = DW - 2;
	localparam int LATENCY     = ITERS + 3;
	localparam int NUM_RANDOM  = 1225;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic               op;
		logic signed [15:0] first;
		logic signed [15:0] second;
	} point_t;

	typedef struct packed {
		logic signed [16:0] first;
		logic signed [15:0] second;
	} coord_out_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               push       = 1'b0;
	logic               opcode     = OP_RECT_TO_POLAR;
	logic signed [15:0] first_in   = '0;
	logic signed [15:0] second_in  = '0;
	logic               pop        = 1'b0;
	logic               full;
	logic               empty;
	logic signed [16:0] first_out;
	logic signed [15:0] second_out;

	point_t     pending_points[$];
	coord_out_t awaited_coords[$];
	int         error_count    = 0;
	int         offered_count  = 0;
	int         received_count = 0;
	int         cycle_count    = 0;

	cartesian_polar_converter #(
		.ITERATIONS(ITERS),
		.DATA_WIDTH(DW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.first_in(first_in),
		.second_in(second_in),
		.empty(empty),
		.pop(pop),
		.first_out(first_out),
		.second_out(second_out)
	);

	always #4 clk = ~clk;

	// q2.14 input to the internal fraction width
	function automatic longint to_fixed(input longint q);
		if (FRAC >= 14)
			return q * (longint'(1) << (FRAC >= 14 ? FRAC - 14 : 0));
		return q >>> (FRAC < 14 ? 14 - FRAC : 0);
	endfunction

	// gain removal, rounded half away from zero
	function automatic longint gain_to_q14(input longint v);
		longint unsigned m;
		longint unsigned p;
		int              s;
		s = FRAC + 16;
		m = (v < 0) ? longint'(-v) : longint'(v);
		p = (m * longint'(INVK) + (64'd1 << (s - 1))) >> s;
		return (v < 0) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic coord_out_t cordic_convert(input point_t p);
		longint      x, y, t, dx, dy, r1, r2;
		logic [31:0] z;
		logic [31:0] zr;
		coord_out_t  res;
		x  = to_fixed(longint'(p.first));
		y  = 0;
		z  = '0;
		r1 = 0;
		r2 = 0;
		if (p.op == OP_RECT_TO_POLAR) begin
			y = to_fixed(longint'(p.second));
			if (x != 0 || y != 0) begin
				// left half-plane: turn by a quarter first
				if (x < 0) begin
					t = x;
					if (y >= 0) begin
						x = y;
						y = -t;
						z = QUARTER;
					end else begin
						x = -y;
						y = t;
						z = 32'd0 - QUARTER;
					end
				end
				for (int i = 0; i < ITERS && i < TABLE_LEN; i++) begin
					dx = y >>> i;
					dy = x >>> i;
					if (y >= 0) begin
						x = x + dx;
						y = y - dy;
						z = z + ATAN_TABLE[i];
					end else begin
						x = x - dx;
						y = y + dy;
						z = z - ATAN_TABLE[i];
					end
				end
				r1 = gain_to_q14(x);
				zr = z + ANG_RND;
				r2 = longint'($signed(zr[31:16]));
			end
		end else begin
			z = {p.second, 16'h0000};
			// beyond a quarter turn: flip the magnitude and rotate by pi
			if (((z + QUARTER) & HALF_TURN) != 0) begin
				x = -x;
				z = z + HALF_TURN;
			end
			for (int i = 0; i < ITERS && i < TABLE_LEN; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z[31] == 1'b0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_TABLE[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_TABLE[i];
				end
			end
			r1 = gain_to_q14(x);
			r2 = gain_to_q14(y);
		end
		r1 = clip(r1, -65536, 65535);
		r2 = clip(r2, -32768, 32767);
		res.first  = r1[16:0];
		res.second = r2[15:0];
		return res;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 16'($urandom);
		if (r < 8)
			return 16'($signed($urandom_range(0, 128)) - 64);
		if (r < 9)
			return $urandom_range(0, 1) ? (16'h7FFF - 16'($urandom_range(0, 2)))
						    : (16'h8000 + 16'($urandom_range(0, 2)));
		return 16'h1 << $urandom_range(0, 15);
	endfunction

	function automatic point_t random_point();
		point_t p;
		p.op     = 1'($urandom_range(0, 1));
		p.first  = pick_value();
		p.second = pick_value();
		// magnitudes are mostly nonnegative
		if (p.op == OP_POLAR_TO_RECT && $urandom_range(0, 99) < 85)
			p.first[15] = 1'b0;
		return p;
	endfunction

	task automatic add_point(input logic op, input logic [15:0] a, input logic [15:0] b);
		pending_points.push_back('{op, a, b});
	endtask

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// driver
	always @(posedge clk) begin
		point_t cur;
		int     gap_left;
		if (arst_n) begin
			if (push && !full) begin
				cur = '{opcode, first_in, second_in};
				awaited_coords.push_back(cordic_convert(cur));
			end
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (pending_points.size() > 0) begin
					cur = pending_points.pop_front();
					opcode    <= cur.op;
					first_in  <= cur.first;
					second_in <= cur.second;
					push      <= 1'b1;
					offered_count++;
					gap_left = ((offered_count % 300) < 50) ? 0 : pick_gap();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		coord_out_t exp_c;
		int         stall_left;
		int         hold_left;
		if (arst_n) begin
			if (pop && !empty) begin
				if (awaited_coords.size() == 0) begin
					flag_mismatch($sformatf("unexpected transaction %0d/%0d",
						first_out, second_out));
				end else begin
					exp_c = awaited_coords.pop_front();
					if (first_out !== exp_c.first)
						flag_mismatch($sformatf("first_out %0d, expected %0d",
							first_out, exp_c.first));
					if (second_out !== exp_c.second)
						flag_mismatch($sformatf("second_out %0d, expected %0d",
							second_out, exp_c.second));
				end
				received_count++;
				if (received_count == 200 || received_count == 700)
					hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				stall_left = ((received_count % 250) < 40) ? 0 : pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		// rectangular to polar: zero vector, axes, corners, left half-plane
		add_point(OP_RECT_TO_POLAR, 16'h0000, 16'h0000);
		add_point(OP_RECT_TO_POLAR, 16'h7FFF, 16'h0000);
		add_point(OP_RECT_TO_POLAR, 16'h8000, 16'h0000);
		add_point(OP_RECT_TO_POLAR, 16'h0000, 16'h7FFF);
		add_point(OP_RECT_TO_POLAR, 16'h0000, 16'h8000);
		add_point(OP_RECT_TO_POLAR, 16'h7FFF, 16'h7FFF);
		add_point(OP_RECT_TO_POLAR, 16'h8000, 16'h8000);
		add_point(OP_RECT_TO_POLAR, 16'h8000, 16'h7FFF);
		add_point(OP_RECT_TO_POLAR, 16'hFFFF, 16'h0000);
		add_point(OP_RECT_TO_POLAR, 16'hFFFF, 16'hFFFF);
		add_point(OP_RECT_TO_POLAR, 16'h0001, 16'h0001);
		add_point(OP_RECT_TO_POLAR, 16'hFF9C, 16'h0032);
		add_point(OP_RECT_TO_POLAR, 16'hFF9C, 16'hFFCE);
		// polar to rectangular: quarter-turn edges, pi, negative magnitude
		add_point(OP_POLAR_TO_RECT, 16'h4000, 16'h0000);
		add_point(OP_POLAR_TO_RECT, 16'h4000, 16'h4000);
		add_point(OP_POLAR_TO_RECT, 16'h4000, 16'h3FFF);
		add_point(OP_POLAR_TO_RECT, 16'h4000, 16'h4001);
		add_point(OP_POLAR_TO_RECT, 16'h4000, 16'hC000);
		add_point(OP_POLAR_TO_RECT, 16'h4000, 16'hBFFF);
		add_point(OP_POLAR_TO_RECT, 16'h4000, 16'h8000);
		add_point(OP_POLAR_TO_RECT, 16'h7FFF, 16'h7FFF);
		add_point(OP_POLAR_TO_RECT, 16'h8000, 16'h4000);
		add_point(OP_POLAR_TO_RECT, 16'h8000, 16'h0000);
		add_point(OP_POLAR_TO_RECT, 16'h0000, 16'h3039);
		add_point(OP_POLAR_TO_RECT, 16'hFFFF, 16'h0064);
		for (int i = 0; i < NUM_RANDOM; i++)
			pending_points.push_back(random_point());

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_points.size() != 0 || push || awaited_coords.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 16) @(negedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
